>>> sv/bffa_pkg.sv
// Shared sizes, codes and state encoding for the bitmap first-fit allocator.
// No dependencies.
`timescale 1ns / 1ps

package bffa_pkg;

  localparam int MAX_ITEMS = 32768;
  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = (MAX_ITEMS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW   = $clog2(NUM_WORDS);
  localparam int BIT_AW    = $clog2(WORD_BITS);
  localparam int FILL_W    = $clog2(NUM_WORDS + 1);
  localparam int LIM_W     = $clog2(MAX_ITEMS + 1);

  localparam int CFG_W     = 16;
  localparam int IDX_W     = 15;
  localparam int CNT_W     = 16;
  localparam int REG_AW    = 1;

  localparam logic [REG_AW-1:0] REG_ITEM_COUNT       = 1'b0;
  localparam logic [REG_AW-1:0] REG_FREE_COUNT_START = 1'b1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_W-1:0] ITEM_COUNT_RESET       = 16'd32768;
  localparam logic [CFG_W-1:0] FREE_COUNT_START_RESET = 16'd32768;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_FREE,
    ST_RESP
  } state_t;

endpackage

>>> sv/bitmap_first_fit_allocator_unit.sv
// Bitmap first-fit allocator: used/free bitmap in one synchronous RAM plus a free counter.
// Depends on bffa_pkg.
`timescale 1ns / 1ps

// One item at a time. An allocate reads the bitmap RAM one 32-bit word per cycle from
// word 0 up to the word holding the lowest free entry below the active limit, k words in
// all (1 to 1024), or up to the last word below the limit if none is free; the single
// RAM read port sets that pace. A free reads the entry's word and then writes it back
// with the bit cleared; a request rejected at once (a free out of range, or an allocate
// with a zero limit) goes straight to its result without scanning or writing the RAM.
// A finished result sits in an output register, so the next item is taken while it
// waits; a second finished result holds until that register is read. There is no
// clearing pass after reset: a fill mark counts the words ever written, and words at or
// above it read as all free. Writing free_count_start reloads the free counter;
// configure only while the block is idle.
module bitmap_first_fit_allocator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [bffa_pkg::REG_AW-1:0]   cfg_index,
  input  logic [bffa_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          req_type,
  input  logic [bffa_pkg::IDX_W-1:0]    entry_index,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [1:0]                    status,
  output logic [bffa_pkg::IDX_W-1:0]    granted_index,
  output logic [bffa_pkg::CNT_W-1:0]    free_count
);

  localparam int WB = bffa_pkg::WORD_BITS;
  localparam int WA = bffa_pkg::WORD_AW;
  localparam int BA = bffa_pkg::BIT_AW;
  localparam int LW = bffa_pkg::LIM_W;
  localparam int FW = bffa_pkg::FILL_W;

  bffa_pkg::state_t state, state_next;

  logic [bffa_pkg::CFG_W-1:0] item_count;
  logic [bffa_pkg::CNT_W-1:0] free_counter;
  logic [FW-1:0]              fill;
  logic [WA-1:0]              scan_word;
  logic [bffa_pkg::IDX_W-1:0] idx_q;
  bffa_pkg::status_t          res_status;
  logic [bffa_pkg::IDX_W-1:0] res_index;

  logic [WB-1:0] mem [bffa_pkg::NUM_WORDS];
  logic [WB-1:0] rd_data;
  logic [WA-1:0] rd_addr_q;
  logic [WA-1:0] raddr;
  logic          mem_we;
  logic [WA-1:0] waddr;
  logic [WB-1:0] wdata;

  logic [LW-1:0]      lim;
  logic [WA-1:0]      last_word;
  logic [LW-BA-1:0]   lim_word;
  logic [WB-1:0]      word_data;
  logic [WB-1:0]      word_mask;
  logic [WB-1:0]      cand;
  logic [WB-1:0]      onehot;
  logic [BA-1:0]      enc;
  logic [WB-1:0]      free_bit;
  logic               req_acc;
  logic               rsp_load;

  logic                       set_res;
  bffa_pkg::status_t          res_status_next;
  logic [bffa_pkg::IDX_W-1:0] res_index_next;
  logic                       cnt_dec;
  logic                       cnt_inc;
  logic                       fill_inc;
  logic                       scan_adv;
  logic                       load_scan;

  assign req_stall = (state != bffa_pkg::ST_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign rsp_load  = (state == bffa_pkg::ST_RESP) && (!rsp_valid || !rsp_stall);

  assign lim = (LW'(item_count) > LW'(bffa_pkg::MAX_ITEMS)) ? LW'(bffa_pkg::MAX_ITEMS)
                                                            : LW'(item_count);
  assign last_word = WA'((lim - 1'b1) >> BA);
  assign lim_word  = lim[LW-1:BA];

  assign word_data = ({1'b0, rd_addr_q} >= fill) ? '0 : rd_data;

  always_comb begin
    if ((LW-BA)'(rd_addr_q) < lim_word) begin
      word_mask = '1;
    end else if ((LW-BA)'(rd_addr_q) == lim_word) begin
      word_mask = (WB'(1) << lim[BA-1:0]) - WB'(1);
    end else begin
      word_mask = '0;
    end
  end

  assign cand   = ~word_data & word_mask;
  assign onehot = cand & (~cand + WB'(1));

  always_comb begin
    enc = '0;
    for (int i = 0; i < WB; i++) begin
      enc = enc | (onehot[i] ? BA'(i) : '0);
    end
  end

  assign free_bit = WB'(1) << idx_q[BA-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_data   <= mem[raddr];
    rd_addr_q <= raddr;
  end

  always_comb begin
    state_next = state;
    case (state)
      bffa_pkg::ST_IDLE: begin
        if (req_acc) begin
          if (req_type == bffa_pkg::OP_ALLOC) begin
            state_next = (lim == '0) ? bffa_pkg::ST_RESP : bffa_pkg::ST_ALLOC;
          end else begin
            state_next = (LW'(entry_index) >= lim) ? bffa_pkg::ST_RESP : bffa_pkg::ST_FREE;
          end
        end
      end
      bffa_pkg::ST_ALLOC: begin
        if (cand != '0 || rd_addr_q == last_word) begin
          state_next = bffa_pkg::ST_RESP;
        end
      end
      bffa_pkg::ST_FREE: begin
        state_next = bffa_pkg::ST_RESP;
      end
      bffa_pkg::ST_RESP: begin
        if (rsp_load) begin
          state_next = bffa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bffa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    raddr           = '0;
    mem_we          = 1'b0;
    waddr           = rd_addr_q;
    wdata           = word_data;
    set_res         = 1'b0;
    res_status_next = bffa_pkg::STATUS_OK;
    res_index_next  = '0;
    cnt_dec         = 1'b0;
    cnt_inc         = 1'b0;
    fill_inc        = 1'b0;
    scan_adv        = 1'b0;
    load_scan       = 1'b0;
    case (state)
      bffa_pkg::ST_IDLE: begin
        raddr = (req_type == bffa_pkg::OP_FREE) ? entry_index[bffa_pkg::IDX_W-1:BA] : '0;
        if (req_acc) begin
          load_scan = 1'b1;
          if (req_type == bffa_pkg::OP_ALLOC && lim == '0) begin
            set_res         = 1'b1;
            res_status_next = bffa_pkg::STATUS_NO_SPACE;
          end else if (req_type == bffa_pkg::OP_FREE && LW'(entry_index) >= lim) begin
            set_res         = 1'b1;
            res_status_next = bffa_pkg::STATUS_RANGE;
          end
        end
      end
      bffa_pkg::ST_ALLOC: begin
        raddr = scan_word + 1'b1;
        if (cand != '0) begin
          mem_we          = 1'b1;
          wdata           = word_data | onehot;
          fill_inc        = ({1'b0, rd_addr_q} == fill);
          cnt_dec         = 1'b1;
          set_res         = 1'b1;
          res_status_next = bffa_pkg::STATUS_OK;
          res_index_next  = {rd_addr_q, enc};
        end else if (rd_addr_q == last_word) begin
          set_res         = 1'b1;
          res_status_next = bffa_pkg::STATUS_NO_SPACE;
        end else begin
          scan_adv = 1'b1;
        end
      end
      bffa_pkg::ST_FREE: begin
        mem_we          = ({1'b0, rd_addr_q} < fill);
        wdata           = word_data & ~free_bit;
        cnt_inc         = 1'b1;
        set_res         = 1'b1;
        res_status_next = bffa_pkg::STATUS_OK;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= bffa_pkg::ST_IDLE;
      item_count       <= bffa_pkg::ITEM_COUNT_RESET;
      free_counter     <= bffa_pkg::FREE_COUNT_START_RESET;
      fill             <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen && cfg_index == bffa_pkg::REG_ITEM_COUNT) begin
        item_count <= cfg_data;
      end
      if (cfg_wen && cfg_index == bffa_pkg::REG_FREE_COUNT_START) begin
        free_counter     <= cfg_data;
      end else if (cnt_dec) begin
        free_counter <= free_counter - 1'b1;
      end else if (cnt_inc) begin
        free_counter <= free_counter + 1'b1;
      end
      if (fill_inc) begin
        fill <= fill + 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_scan) begin
      scan_word <= '0;
      idx_q     <= entry_index;
    end else if (scan_adv) begin
      scan_word <= scan_word + 1'b1;
    end
    if (set_res) begin
      res_status <= res_status_next;
      res_index  <= res_index_next;
    end
    if (rsp_load) begin
      status        <= res_status;
      granted_index <= res_index;
      free_count    <= free_counter;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(bffa_pkg::NUM_WORDS))
    else $error("fill mark beyond bitmap depth");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == bffa_pkg::ST_ALLOC || state == bffa_pkg::ST_FREE))
    else $error("bitmap write outside allocate or free");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == bffa_pkg::ST_RESP)
    else $error("result shown without a finished item");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> state != bffa_pkg::ST_IDLE)
    else $error("accepted item did not start");

  a_alloc_hit: assert property (@(posedge clk) disable iff (rst)
    (state == bffa_pkg::ST_ALLOC && mem_we) |-> $onehot(onehot))
    else $error("allocate write without a single free bit");
`endif

endmodule
